>>> rtl/core/syjvc_pkg.sv
// Package for the synchronized joint velocity controller.
// Holds field widths, register defaults, command codes and shared types.
// No dependencies.
`default_nettype none

package syjvc_pkg;

  localparam int JointCount = 6;
  localparam int AngleBits  = 16;
  localparam int GainBits   = 12;
  localparam int TolBits    = 15;
  localparam int SpeedBits  = 14;
  localparam int CountBits  = 4;
  localparam int ActionBits = 2;
  localparam int MagBits    = AngleBits;
  localparam int ErrBits    = AngleBits + 1;
  localparam int IdxBits    = (JointCount > 1) ? $clog2(JointCount) : 1;
  localparam int StepBits   = $clog2(GainBits + 1);

  localparam int InDataBits  = ((CountBits + JointCount * AngleBits + 7) / 8) * 8;
  localparam int OutDataBits = ((JointCount * SpeedBits + 7) / 8) * 8;

  localparam int ApbAddrBits = 3;
  localparam int ApbDataBits = 32;

  localparam logic [GainBits-1:0] GainReset = GainBits'(1024);
  localparam logic [TolBits-1:0]  TolReset  = TolBits'(123);

  localparam logic RegGain = 1'b0;
  localparam logic RegTol  = 1'b1;

  typedef enum logic [ActionBits-1:0] {
    ACT_MEAS = 2'd0,
    ACT_TGT  = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic gain_bit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/syjvc_lane.sv
// One joint lane: error, magnitude and a radix-2 serial divider for gain*|err|/largest.
// Consumes one gain bit per step, MSB first, quotient digit 0..2 per step.
// Depends on syjvc_pkg.
`default_nettype none

module syjvc_lane (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  syjvc_pkg::lane_ctrl_t                  ctrl_i,
  input  logic signed [syjvc_pkg::AngleBits-1:0] meas_i,
  input  logic signed [syjvc_pkg::AngleBits-1:0] tgt_i,
  input  logic        [syjvc_pkg::MagBits-1:0]   divisor_i,
  input  logic        [syjvc_pkg::TolBits-1:0]   tol_i,
  output logic        [syjvc_pkg::MagBits-1:0]   mag_o,
  output logic signed [syjvc_pkg::SpeedBits-1:0] speed_o
);
  import syjvc_pkg::*;

  localparam int SumBits = MagBits + 2;

  logic signed [ErrBits-1:0] err;
  logic [ErrBits-1:0]        mag_full;
  logic                      neg;
  logic                      above_tol;
  logic [SumBits-1:0]        sum, two_div, one_div;
  logic [1:0]                digit;
  logic [MagBits-1:0]        rem_d, rem_q;
  logic [GainBits:0]         quo_wide;
  logic [GainBits-1:0]       quo_d, quo_q;
  logic                      neg_d, neg_q, active_d, active_q;
  logic [SpeedBits-1:0]      quo_ext;

  assign err       = {tgt_i[AngleBits-1], tgt_i} - {meas_i[AngleBits-1], meas_i};
  assign neg       = err[ErrBits-1];
  assign mag_full  = neg ? ErrBits'(-err) : ErrBits'(err);
  assign mag_o     = mag_full[MagBits-1:0];
  assign above_tol = {{TolBits{1'b0}}, mag_o} > {{MagBits{1'b0}}, tol_i};

  assign sum     = {1'b0, rem_q, 1'b0} + (ctrl_i.gain_bit ? {2'b00, mag_o} : '0);
  assign two_div = {1'b0, divisor_i, 1'b0};
  assign one_div = {2'b00, divisor_i};

  always_comb begin
    if (sum >= two_div) begin
      digit = 2'd2;
      rem_d = MagBits'(sum - two_div);
    end else if (sum >= one_div) begin
      digit = 2'd1;
      rem_d = MagBits'(sum - one_div);
    end else begin
      digit = 2'd0;
      rem_d = sum[MagBits-1:0];
    end
  end

  assign quo_wide = {quo_q, 1'b0} + {{(GainBits-1){1'b0}}, digit};
  assign quo_d    = quo_wide[GainBits-1:0];

  always_comb begin
    neg_d    = neg_q;
    active_d = active_q;
    if (ctrl_i.load) begin
      neg_d    = neg;
      active_d = above_tol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      neg_q    <= neg_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_ext = {{(SpeedBits-GainBits){1'b0}}, quo_q};

  always_comb begin
    if (!active_q) begin
      speed_o = '0;
    end else if (neg_q) begin
      speed_o = SpeedBits'(-quo_ext);
    end else begin
      speed_o = quo_ext;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/synchronized_joint_velocity_control.sv
// Top level of the synchronized joint velocity controller.
// Holds position storage, the scan and divide sequencer, the APB registers and the stream ports.
// Depends on syjvc_pkg and syjvc_lane.
//
// Usage: the slave stream carries one transaction per command. tuser holds the action
// (measured positions, target positions, control tick); tdata holds value_count and six
// Q3.12 angles. Position sets with value_count below six are dropped. A tick, once both
// kinds of set have been stored, yields one result on the master stream: six Q1.12 speeds
// in tdata and the at-goal flag in tuser.
// Sequence: a tick is accepted, then the scan finds the largest error (one joint per cycle),
// the divide runs (one gain bit per cycle, six lanes in parallel) and the output register
// is loaded; the divide is skipped when the largest error is within tolerance.
// The output register holds a result until the receiver takes it; position sets are still
// accepted meanwhile, and a following tick waits in its final cycle while the receiver stalls.
// Reset clears both known flags and stored positions and loads gain 1024, tolerance 123.
// Registers: byte address 0 velocity_gain, 4 error_tolerance, written through the APB port.
`default_nettype none

module synchronized_joint_velocity_control (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: value_count, value_1 .. value_6, zero pad
  input  logic [syjvc_pkg::InDataBits-1:0]      s_axis_tdata,
  // tuser: action
  input  logic [syjvc_pkg::ActionBits-1:0]      s_axis_tuser,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: speed_1 .. speed_6, zero pad
  output logic [syjvc_pkg::OutDataBits-1:0]     m_axis_tdata,
  // tuser: at_goal
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [syjvc_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [syjvc_pkg::ApbDataBits-1:0]     pwdata,
  output logic [syjvc_pkg::ApbDataBits-1:0]     prdata,
  output logic                                  pready
);
  import syjvc_pkg::*;

  state_e state_d, state_q;

  logic signed [AngleBits-1:0] meas_q [JointCount];
  logic signed [AngleBits-1:0] tgt_q  [JointCount];
  logic meas_known_d, meas_known_q, tgt_known_d, tgt_known_q;

  logic [GainBits-1:0] gain_q;
  logic [TolBits-1:0]  tol_q;

  logic [IdxBits-1:0]  idx_d, idx_q;
  logic [StepBits-1:0] cnt_d, cnt_q;
  logic [MagBits-1:0]  largest_d, largest_q, largest_nxt, mag_sel;
  logic [GainBits-1:0] gain_sr_d, gain_sr_q;
  logic                goal_d, goal_q;
  logic                largest_gt_tol, nxt_gt_tol;

  logic                     out_valid_d, out_valid_q;
  logic [OutDataBits-1:0]   out_data_q, out_pack;
  logic                     out_goal_q;
  logic                     out_load;

  lane_ctrl_t                  lane_ctrl;
  logic [MagBits-1:0]          lane_mag   [JointCount];
  logic signed [SpeedBits-1:0] lane_speed [JointCount];

  logic          in_accept, store_set, apb_write;
  action_e       action;
  logic [CountBits-1:0] value_count;

  assign action      = action_e'(s_axis_tuser);
  assign value_count = s_axis_tdata[CountBits-1:0];
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign store_set   = in_accept && (value_count >= CountBits'(JointCount));

  for (genvar j = 0; j < JointCount; j++) begin : g_lane
    syjvc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .meas_i    (meas_q[j]),
      .tgt_i     (tgt_q[j]),
      .divisor_i (largest_q),
      .tol_i     (tol_q),
      .mag_o     (lane_mag[j]),
      .speed_o   (lane_speed[j])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meas_q[j] <= '0;
        tgt_q[j]  <= '0;
      end else if (store_set && action == ACT_MEAS) begin
        meas_q[j] <= s_axis_tdata[CountBits + j*AngleBits +: AngleBits];
      end else if (store_set && action == ACT_TGT) begin
        tgt_q[j] <= s_axis_tdata[CountBits + j*AngleBits +: AngleBits];
      end
    end
  end

  assign mag_sel        = lane_mag[idx_q];
  assign largest_nxt    = (mag_sel > largest_q) ? mag_sel : largest_q;
  assign nxt_gt_tol     = {{TolBits{1'b0}}, largest_nxt} > {{MagBits{1'b0}}, tol_q};
  assign largest_gt_tol = {{TolBits{1'b0}}, largest_q} > {{MagBits{1'b0}}, tol_q};

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    cnt_d          = cnt_q;
    largest_d      = largest_q;
    gain_sr_d      = gain_sr_q;
    goal_d         = goal_q;
    meas_known_d   = meas_known_q;
    tgt_known_d    = tgt_known_q;
    out_load       = 1'b0;
    lane_ctrl      = '0;
    lane_ctrl.gain_bit = gain_sr_q[GainBits-1];
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (action)
            ACT_MEAS: if (store_set) meas_known_d = 1'b1;
            ACT_TGT:  if (store_set) tgt_known_d = 1'b1;
            ACT_TICK: begin
              if (meas_known_q && tgt_known_q) begin
                state_d   = ST_SCAN;
                idx_d     = '0;
                largest_d = '0;
                gain_sr_d = gain_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        largest_d = largest_nxt;
        if (idx_q == IdxBits'(JointCount - 1)) begin
          cnt_d = '0;
          if (nxt_gt_tol) begin
            goal_d         = 1'b0;
            lane_ctrl.load = 1'b1;
            state_d        = ST_DIV;
          end else begin
            goal_d  = 1'b1;
            state_d = ST_EMIT;
          end
        end else begin
          idx_d = idx_q + IdxBits'(1);
        end
      end
      ST_DIV: begin
        lane_ctrl.step = 1'b1;
        gain_sr_d      = {gain_sr_q[GainBits-2:0], 1'b0};
        cnt_d          = cnt_q + StepBits'(1);
        if (cnt_q == StepBits'(GainBits - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_pack = '0;
    for (int j = 0; j < JointCount; j++) begin
      out_pack[j*SpeedBits +: SpeedBits] = goal_q ? '0 : lane_speed[j];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      goal_q       <= 1'b0;
      meas_known_q <= 1'b0;
      tgt_known_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      largest_q    <= '0;
      gain_sr_q    <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      goal_q       <= goal_d;
      meas_known_q <= meas_known_d;
      tgt_known_q  <= tgt_known_d;
      out_valid_q  <= out_valid_d;
      largest_q    <= largest_d;
      gain_sr_q    <= gain_sr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_pack;
      out_goal_q <= goal_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_goal_q;

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      tol_q  <= TolReset;
    end else if (apb_write) begin
      case (paddr[ApbAddrBits-1])
        RegGain: gain_q <= pwdata[GainBits-1:0];
        RegTol:  tol_q  <= pwdata[TolBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ApbAddrBits-1])
      RegGain: prdata = ApbDataBits'(gain_q);
      RegTol:  prdata = ApbDataBits'(tol_q);
      default: prdata = '0;
    endcase
  end

  a_goal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("at-goal result carries nonzero speeds");

  a_div_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> largest_gt_tol)
    else $error("divide entered with largest error within tolerance");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < StepBits'(GainBits))
    else $error("divide step count overran");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("result load did not return to idle with valid output");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for synchronized_joint_velocity_control: stream commands in,
// speed results out. It predicts each tick's speeds and checks them in a scoreboard class.
// Depends on syjvc_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
  import syjvc_pkg::*;

  localparam logic [ActionBits-1:0] ActUnused = 2'd3;
  localparam int DrainCycles = 30;
  localparam int QuietLimit  = 4000;

  typedef logic [JointCount-1:0][AngleBits-1:0] angle_set_t;

  typedef struct packed {
    logic                                at_goal;
    logic [JointCount-1:0][SpeedBits-1:0] speed;
  } speed_cmd_t;

  class speed_scoreboard;
    logic signed [AngleBits-1:0] meas_angle[JointCount];
    logic signed [AngleBits-1:0] tgt_angle[JointCount];
    logic                        meas_known;
    logic                        tgt_known;
    logic [GainBits-1:0]         gain;
    logic [TolBits-1:0]          tol;
    speed_cmd_t                  pending_cmds[$];
    int                          errors;

    function new();
      foreach (meas_angle[j]) begin
        meas_angle[j] = '0;
        tgt_angle[j]  = '0;
      end
      meas_known = 1'b0;
      tgt_known  = 1'b0;
      gain       = GainReset;
      tol        = TolReset;
      errors     = 0;
    endfunction

    function void note_command(logic [ActionBits-1:0] action, logic [CountBits-1:0] count,
                               angle_set_t angles);
      speed_cmd_t cmd;
      int         err[JointCount];
      int         mag[JointCount];
      int         largest;
      int         q;
      if (action == ACT_MEAS || action == ACT_TGT) begin
        if (count < JointCount) return;
        for (int j = 0; j < JointCount; j++) begin
          if (action == ACT_MEAS) meas_angle[j] = angles[j];
          else tgt_angle[j] = angles[j];
        end
        if (action == ACT_MEAS) meas_known = 1'b1;
        else tgt_known = 1'b1;
        return;
      end
      if (action != ACT_TICK || !meas_known || !tgt_known) return;
      largest = 0;
      for (int j = 0; j < JointCount; j++) begin
        err[j] = int'(tgt_angle[j]) - int'(meas_angle[j]);
        mag[j] = (err[j] < 0) ? -err[j] : err[j];
        if (mag[j] > largest) largest = mag[j];
      end
      cmd = '0;
      if (largest <= int'(tol)) begin
        cmd.at_goal = 1'b1;
      end else begin
        for (int j = 0; j < JointCount; j++) begin
          q = (mag[j] > int'(tol)) ? (int'(gain) * mag[j]) / largest : 0;
          if (err[j] < 0) q = -q;
          cmd.speed[j] = q[SpeedBits-1:0];
        end
      end
      pending_cmds.push_back(cmd);
    endfunction

    function void check_speeds(logic [OutDataBits-1:0] data, logic at_goal);
      speed_cmd_t           want;
      logic [SpeedBits-1:0] got;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual speeds %h at_goal %0b",
                 $time, data, at_goal);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      for (int j = 0; j < JointCount; j++) begin
        got = data[SpeedBits*j +: SpeedBits];
        if (got !== want.speed[j]) begin
          $display("%0t: speed_%0d expected %0d actual %0d", $time, j + 1,
                   $signed(want.speed[j]), $signed(got));
          errors++;
        end
      end
      if (at_goal !== want.at_goal) begin
        $display("%0t: at_goal expected %0b actual %0b", $time, want.at_goal, at_goal);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic [InDataBits-1:0]   s_axis_tdata;
  logic [ActionBits-1:0]   s_axis_tuser;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [OutDataBits-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrBits-1:0]  paddr;
  logic [ApbDataBits-1:0]  pwdata;
  logic [ApbDataBits-1:0]  prdata;
  logic                    pready;

  speed_scoreboard board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  synchronized_joint_velocity_control u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready = rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_speeds(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  function automatic angle_set_t joint_set(int a1, int a2, int a3, int a4, int a5, int a6);
    angle_set_t s;
    s[0] = a1[AngleBits-1:0];
    s[1] = a2[AngleBits-1:0];
    s[2] = a3[AngleBits-1:0];
    s[3] = a4[AngleBits-1:0];
    s[4] = a5[AngleBits-1:0];
    s[5] = a6[AngleBits-1:0];
    return s;
  endfunction

  function automatic angle_set_t rand_angles();
    angle_set_t s;
    for (int j = 0; j < JointCount; j++) s[j] = AngleBits'($urandom);
    return s;
  endfunction

  // land on the tolerance edges around the other stored set
  function automatic logic [AngleBits-1:0] near_angle(logic [AngleBits-1:0] base);
    int t;
    int d;
    t = int'(board.tol);
    case ($urandom_range(0, 5))
      0: d = 0;
      1: d = t;
      2: d = -t;
      3: d = t + 1;
      4: d = -(t + 1);
      default: d = int'($urandom_range(0, 4 * t + 16)) - (2 * t + 8);
    endcase
    return base + d[AngleBits-1:0];
  endfunction

  task automatic send_command(input logic [ActionBits-1:0] action,
                              input logic [CountBits-1:0] count, input angle_set_t angles);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tdata = '0;
    s_axis_tdata[CountBits-1:0] = count;
    for (int j = 0; j < JointCount; j++) begin
      s_axis_tdata[CountBits + AngleBits*j +: AngleBits] = angles[j];
    end
    s_axis_tuser  = action;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_command(action, count, angles);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [ApbDataBits-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegGain) board.gain = value[GainBits-1:0];
    else board.tol = value[TolBits-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (board.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_command();
    int                    pick;
    logic [ActionBits-1:0] action;
    logic [CountBits-1:0]  count;
    angle_set_t            angles;
    pick   = $urandom_range(0, 99);
    angles = rand_angles();
    count  = CountBits'($urandom_range(JointCount, 15));
    if (pick < 30) begin
      action = ACT_MEAS;
    end else if (pick < 60) begin
      action = ACT_TGT;
    end else if (pick < 90) begin
      action = ACT_TICK;
      count  = CountBits'($urandom);
    end else if (pick < 95) begin
      action = ActionBits'($urandom_range(0, 1));
      count  = CountBits'($urandom_range(0, JointCount - 1));
    end else begin
      action = ActUnused;
      count  = CountBits'($urandom);
    end
    if ((action == ACT_MEAS || action == ACT_TGT) && count >= JointCount &&
        $urandom_range(0, 3) != 0) begin
      for (int j = 0; j < JointCount; j++) begin
        if ($urandom_range(0, 4) != 0) begin
          angles[j] = near_angle(action == ACT_MEAS ? board.tgt_angle[j] : board.meas_angle[j]);
        end
      end
    end
    send_command(action, count, angles);
  endtask

  initial begin
    angle_set_t meas_set;
    logic [GainBits-1:0] gain_val;
    logic [TolBits-1:0]  tol_val;
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_command(ACT_TICK, 4'd6, rand_angles());
    send_command(ACT_MEAS, 4'd5, rand_angles());
    send_command(ACT_TGT, 4'd0, rand_angles());
    send_command(ACT_MEAS, 4'd6, {JointCount{16'h8000}});
    send_command(ACT_TICK, 4'd0, '0);
    send_command(ActUnused, 4'hF, {JointCount{16'hFFFF}});
    send_command(ACT_TGT, 4'hF, {JointCount{16'h7FFF}});
    send_command(ACT_TICK, 4'hF, rand_angles());
    meas_set = joint_set(0, 1000, -1000, 32767, -32768, 5);
    send_command(ACT_MEAS, 4'd6, meas_set);
    send_command(ACT_TGT, 4'd6, joint_set(123, 877, -1000, 32645, -32767, 55));
    send_command(ACT_TICK, 4'd9, rand_angles());
    send_command(ACT_TGT, 4'd6, joint_set(124, 876, -877, 32644, -32768, 3005));
    send_command(ACT_TICK, 4'd0, '0);
    send_command(ACT_MEAS, 4'd5, rand_angles());
    send_command(ACT_TICK, 4'd3, rand_angles());
    send_command(ACT_MEAS, 4'd7, {3{16'hAAAA, 16'h5555}});
    send_command(ACT_TGT, 4'd6, {3{16'h5555, 16'hAAAA}});
    send_command(ACT_TICK, 4'd6, '1);
    send_command(ActUnused, 4'd0, '0);
    send_command(ACT_TICK, 4'd1, rand_angles());

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin gain_val = '1;                        tol_val = '0; end
        1: begin gain_val = '0;                        tol_val = '1; end
        2: begin gain_val = GainBits'(1);              tol_val = TolBits'(1); end
        3: begin gain_val = GainBits'($urandom);       tol_val = TolBits'($urandom_range(0, 400)); end
        4: begin gain_val = GainBits'(2048);           tol_val = TolReset; end
        default: begin gain_val = GainBits'($urandom); tol_val = TolBits'($urandom); end
      endcase
      write_reg(RegGain, ($urandom & ~32'hFFF) | ApbDataBits'(gain_val));
      write_reg(RegTol, ($urandom & ~32'h7FFF) | ApbDataBits'(tol_val));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      repeat (120) random_command();
    end

    settle();
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
